@@ hw/rtl/aobt_pkg.sv @@
package aobt_pkg;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

	localparam logic [1:0] OP_WHITE   = 2'd0;
	localparam logic [1:0] OP_BLOCK   = 2'd1;
	localparam logic [1:0] OP_OFFENSE = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [2:0] ST_MARKED   = 3'd0;
	localparam logic [2:0] ST_WHITE    = 3'd1;
	localparam logic [2:0] ST_BLOCKED  = 3'd2;
	localparam logic [2:0] ST_WOULD    = 3'd3;
	localparam logic [2:0] ST_COUNTED  = 3'd4;
	localparam logic [2:0] ST_NEWBLOCK = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;

	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_WINDOW    = 2'd1;
	localparam logic [1:0] CFG_DRY_RUN   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HASH_X,
		S_HASH_M0,
		S_HASH_M1,
		S_HASH_M2,
		S_HASH_M3,
		S_RD,
		S_WAIT,
		S_CHECK,
		S_UPDATE,
		S_DONE,
		S_CLEAR
	} state_t;

	// entry record as stored: valid flag is separate
	typedef struct packed {
		logic [127:0] address;
		logic         white;
		logic         blocked;
		logic [15:0]  hits;
		logic [31:0]  window_start;
	} entry_t;

endpackage

@@ hw/rtl/address_offense_block_table_top.sv @@
// Address offense table: one request in, one result out. Each request passes
// an accept state, hashing (sixteen address bytes, one xor and four 16x64
// partial-product steps of the shared multiplier per byte), read, wait and
// compare states for the home slot of the table memory and a wait and compare
// state for each further probed slot, an update state and an output state
// that is held until the result is taken. The unused op goes straight to the
// output after its accept state. The table validity is kept in the memory
// itself, so after reset a clearing pass over all TABLE_ENTRIES slots runs
// before the first request is taken; configuration writes are taken at any
// time.
module address_offense_block_table_top
	import aobt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   op,
	input  logic [63:0]  address_high,
	input  logic [63:0]  address_low,
	input  logic [31:0]  timestamp,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   status,
	output logic [15:0]  hit_count
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int EW = $bits(entry_t) + 1;
	localparam int CW = AW + 1;

	state_t state_q, state_d;

	logic [15:0]  thr_q, win_q;
	logic         dry_q;
	logic [1:0]   op_q;
	logic [127:0] addr_q;
	logic [31:0]  now_q;
	logic [63:0]  h_q, acc_q;
	logic [3:0]   byte_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]   st_q;
	logic [15:0]  cnt_out_q;
	logic         we;
	logic [EW-1:0] wdata, rdata;
	logic [AW-1:0] waddr;
	entry_t       rd_e, wr_e;
	logic         rd_v;
	logic         found_q, fresh_q;
	logic [1:0]   mstep_q;

	assign rd_v = rdata[EW-1];
	assign rd_e = entry_t'(rdata[EW-2:0]);

	aobt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(idx_q), .rdata(rdata)
	);

	// shared multiplier step: 16-bit slice of the prime times the hash
	logic [15:0] pslice;
	logic [63:0] pprod;
	always_comb begin
		case (mstep_q)
			2'd0: pslice = FNV_PRIME[15:0];
			2'd1: pslice = FNV_PRIME[31:16];
			2'd2: pslice = FNV_PRIME[47:32];
			default: pslice = FNV_PRIME[63:48];
		endcase
		pprod = h_q * {48'd0, pslice};
	end

	logic [7:0] cur_byte;
	assign cur_byte = addr_q[127 - 8*byte_q -: 8];

	logic        match;
	logic [31:0] diff;
	logic        restart;
	logic [15:0] new_hits;
	assign match = rd_v && (rd_e.address == addr_q);
	assign diff = now_q - rd_e.window_start;
	assign restart = fresh_q || (rd_e.hits == 16'd0) ||
		(!diff[31] && (diff > {16'd0, win_q}));
	assign new_hits = restart ? 16'd1 :
		((rd_e.hits == 16'hffff) ? rd_e.hits : rd_e.hits + 16'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (cnt_q == CW'(TABLE_ENTRIES - 1)) state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = (op == OP_UNUSED) ? S_DONE : S_HASH_X;
			S_HASH_X: state_d = S_HASH_M0;
			S_HASH_M0: state_d = S_HASH_M1;
			S_HASH_M1: state_d = S_HASH_M2;
			S_HASH_M2: state_d = S_HASH_M3;
			S_HASH_M3: state_d = (byte_q == 4'd15) ? S_RD : S_HASH_X;
			S_RD: state_d = S_WAIT;
			S_WAIT: state_d = S_CHECK;
			S_CHECK: begin
				if (!rd_v || match) state_d = S_UPDATE;
				else if (cnt_q == CW'(TABLE_ENTRIES - 1)) state_d = S_UPDATE;
				else state_d = S_WAIT;
			end
			S_UPDATE: state_d = S_DONE;
			S_DONE: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_DONE);
		status    = st_q;
		hit_count = cnt_out_q;
	end

	// write decision for the clearing pass and the update step
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wr_e  = rd_e;
		if (!found_q) begin
			wr_e.address = addr_q;
			wr_e.white = 1'b0;
			wr_e.blocked = 1'b0;
			wr_e.hits = 16'd0;
			wr_e.window_start = 32'd0;
		end
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = cnt_q[AW-1:0];
		end else if (state_q == S_UPDATE && st_q == ST_MARKED && op_q != OP_UNUSED) begin
			if (op_q == OP_WHITE) begin
				we = 1'b1;
				wr_e.white = 1'b1;
			end else if (op_q == OP_BLOCK) begin
				we = 1'b1;
				wr_e.blocked = 1'b1;
			end else begin
				we = 1'b1;
				wr_e.hits = new_hits;
				if (restart) wr_e.window_start = now_q;
				if ({16'd0, new_hits} >= {16'd0, thr_q}) wr_e.blocked = 1'b1;
			end
		end
		wdata = (state_q == S_CLEAR) ? '0 : {1'b1, wr_e};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			thr_q <= 16'd1;
			win_q <= 16'd60;
			dry_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_THRESHOLD: thr_q <= cfg_data;
					CFG_WINDOW: win_q <= cfg_data;
					CFG_DRY_RUN: dry_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == S_CLEAR || state_q == S_CHECK) cnt_q <= cnt_q + CW'(1);
			else if (state_q == S_IDLE) cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= op;
				addr_q <= {address_high, address_low};
				now_q <= timestamp;
				h_q <= FNV_BASIS;
				byte_q <= 4'd0;
				st_q <= ST_MARKED;
				cnt_out_q <= 16'd0;
				fresh_q <= 1'b0;
				found_q <= 1'b0;
			end
			S_HASH_X: begin
				h_q <= h_q ^ {56'd0, cur_byte};
				acc_q <= '0;
				mstep_q <= 2'd0;
			end
			S_HASH_M0, S_HASH_M1, S_HASH_M2: begin
				acc_q <= acc_q + (pprod << (16 * mstep_q));
				mstep_q <= mstep_q + 2'd1;
			end
			S_HASH_M3: begin
				h_q <= acc_q + (pprod << 48);
				byte_q <= byte_q + 4'd1;
			end
			S_RD: idx_q <= h_q[AW-1:0];
			S_CHECK: begin
				if (!rd_v || match) begin
					found_q <= match;
					fresh_q <= !rd_v;
					if (op_q == OP_OFFENSE) begin
						if (match && rd_e.white) st_q <= ST_WHITE;
						else if (match && rd_e.blocked) st_q <= ST_BLOCKED;
						else if (dry_q) st_q <= ST_WOULD;
					end
				end else if (cnt_q == CW'(TABLE_ENTRIES - 1)) begin
					if (dry_q && op_q == OP_OFFENSE) st_q <= ST_WOULD;
					else st_q <= ST_FULL;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
			S_UPDATE: begin
				if (st_q == ST_MARKED && op_q == OP_OFFENSE) begin
					cnt_out_q <= new_hits;
					st_q <= ({16'd0, new_hits} >= {16'd0, thr_q}) ? ST_NEWBLOCK : ST_COUNTED;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/aobt_ram.sv @@
module aobt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
